// File: src/trint_pkg.sv
package trint_pkg;

    localparam int NUM_CONTEXTS = 4;
    localparam int NUM_TYPES    = 4;
    localparam int MAX_WIDTHS   = 8;
    localparam int MAX_LENGTHS  = 8;

    localparam int NUM_LISTS = NUM_CONTEXTS * NUM_TYPES;
    localparam int LI_W      = $clog2(NUM_LISTS);
    localparam int WS_W      = (MAX_WIDTHS > 1) ? $clog2(MAX_WIDTHS) : 1;
    localparam int LS_W      = (MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1;
    localparam int WCNT_W    = $clog2(MAX_WIDTHS + 1);
    localparam int LCNT_W    = $clog2(MAX_LENGTHS + 1);
    localparam int WADDR_W   = LI_W + WS_W;
    localparam int LADDR_W   = WADDR_W + LS_W;
    localparam int TYPE_CW   = 4;

    localparam logic [31:0] EMPTY_RES = 32'd2560000;   // 1E4 ohms per square
    localparam logic [39:0] RES_MAX   = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic KIND_INSERT = 1'b0;

    typedef logic [MAX_WIDTHS-1:0][WS_W-1:0]  word_t;   // width order of one list
    typedef logic [MAX_LENGTHS-1:0][LS_W-1:0] lord_t;   // length order of one width

    typedef struct packed {
        logic [LCNT_W-1:0] cnt;
        lord_t             ord;
    } meta_t;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] val;
    } lpt_t;

    typedef enum logic [2:0] {
        OP_RSQ   = 3'b001,
        OP_LERP  = 3'b010,
        OP_SCALE = 3'b100
    } op_t;

    function automatic word_t ins_word(word_t o, logic [WCNT_W-1:0] pos,
                                       logic [WS_W-1:0] v);
        word_t r;
        for (int i = 0; i < MAX_WIDTHS; i++) begin
            if (i < int'(pos))
                r[i] = o[i];
            else if (i == int'(pos))
                r[i] = v;
            else
                r[i] = o[i-1];
        end
        return r;
    endfunction

    function automatic lord_t ins_lord(lord_t o, logic [LCNT_W-1:0] pos,
                                       logic [LS_W-1:0] v);
        lord_t r;
        for (int i = 0; i < MAX_LENGTHS; i++) begin
            if (i < int'(pos))
                r[i] = o[i];
            else if (i == int'(pos))
                r[i] = v;
            else
                r[i] = o[i-1];
        end
        return r;
    endfunction

endpackage

// File: src/transistor_resistance_interpolator.sv
// Stores resistance points per (context, type, width, length) and answers
// queries with interpolated static, dynamic-low and dynamic-high resistance.
// Items run one at a time: busy stays high from the accepted start until the
// cycle after done. All arithmetic goes through one 32x32 multiplier and one
// bit-serial divider, so an insert costs one division plus a walk over the
// widths and lengths, and a query three passes of up to 4 divisions each
// plus a walk over the list points. done pulses for one cycle with the result;
// the receiver must take it then, there is no way to stall it.
module transistor_resistance_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        kind,
    input  logic [1:0]  context_req,
    input  logic [1:0]  device_type,
    input  logic [31:0] width,
    input  logic [31:0] length,
    input  logic [31:0] resist,
    output logic [1:0]  status,
    output logic [39:0] r_static,
    output logic [39:0] r_dynlow,
    output logic [39:0] r_dynhigh
);
    import trint_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_ISTART = 17'h00002,
        S_QSTART = 17'h00004,
        S_MUL    = 17'h00008,
        S_DIV    = 17'h00010,
        S_FIN    = 17'h00020,
        S_WRD    = 17'h00040,
        S_WCHK   = 17'h00080,
        S_NEWW   = 17'h00100,
        S_MRD    = 17'h00200,
        S_MCHK   = 17'h00400,
        S_LRD    = 17'h00800,
        S_LCHK   = 17'h01000,
        S_NEWL   = 17'h02000,
        S_LLDONE = 17'h04000,
        S_SCALE  = 17'h08000,
        S_OUT    = 17'h10000
    } state_t;

    state_t state_reg;
    op_t    op_reg;

    logic              kind_reg;
    logic [1:0]        ctx_reg, typ_reg, qi_reg;
    logic [31:0]       w_reg, l_reg, res_reg;
    logic [LI_W-1:0]   li_reg;
    logic [WCNT_W-1:0] wcnt_reg [NUM_LISTS];
    word_t             word_reg [NUM_LISTS];
    logic [WCNT_W-1:0] k_reg;
    logic [LCNT_W-1:0] j_reg, m_reg;
    lord_t             lord_reg;
    logic [WS_W-1:0]   slot_reg, slotb_reg, prevslot_reg;
    logic [31:0]       prevw_reg, x1w_reg, x2w_reg, prevl_reg, prevv_reg;
    logic [31:0]       y_reg, ya_reg, p_reg, rsq_reg, ybase_reg;
    logic              neg_reg, phase_reg, two_reg;
    logic [31:0]       mul_a_reg, mul_b_reg, div_d_reg;
    logic [63:0]       dq_reg;
    logic [31:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic [1:0]        status_reg;
    logic [39:0]       r_reg [3];

    // shared divider step
    logic [32:0] trial;
    logic        qbit;
    assign trial = {rem_reg, dq_reg[63]};
    assign qbit  = (trial >= {1'b0, div_d_reg});

    // list of the current query pass: static, dynamic-low, dynamic-high
    logic [1:0]      qctx;
    logic [LI_W-1:0] li_q, li_i;
    logic            qtype_bad, itype_bad;
    always_comb
    begin
        unique case (qi_reg)
            2'd0:    qctx = 2'd0;
            2'd1:    qctx = 2'd2;
            default: qctx = 2'd1;
        endcase
    end
    assign li_q = LI_W'(LI_W'(qctx) * LI_W'(NUM_TYPES) + LI_W'(typ_reg));
    assign li_i = LI_W'(LI_W'(ctx_reg) * LI_W'(NUM_TYPES) + LI_W'(typ_reg));
    assign qtype_bad = (TYPE_CW'(typ_reg) >= TYPE_CW'(NUM_TYPES));
    assign itype_bad = qtype_bad;

    logic [WCNT_W-1:0] n_cur;
    word_t             word_cur;
    logic [WS_W-1:0]   wslot_k;
    assign n_cur    = wcnt_reg[li_reg];
    assign word_cur = word_reg[li_reg];
    assign wslot_k  = word_cur[k_reg[WS_W-1:0]];

    // memories
    logic [31:0]        wram_q;
    meta_t              mram_q, mram_wd;
    lpt_t               lram_q, lram_wd;
    logic               wram_we, mram_we, lram_we;
    logic [WADDR_W-1:0] mram_wa;
    logic [LADDR_W-1:0] lram_wa, lram_ra;

    assign wram_we = (state_reg == S_NEWW) && (n_cur < WCNT_W'(MAX_WIDTHS));
    assign lram_ra = {li_reg, slot_reg, lord_reg[j_reg[LS_W-1:0]]};
    assign lram_wd = '{len: l_reg, val: rsq_reg};

    always_comb
    begin
        mram_we = 1'b0;
        mram_wa = {li_reg, slot_reg};
        mram_wd = '{cnt: '0, ord: lord_reg};
        lram_we = 1'b0;
        lram_wa = lram_ra;
        if (wram_we)
        begin
            mram_we = 1'b1;
            mram_wa = {li_reg, n_cur[WS_W-1:0]};
        end
        else if (state_reg == S_NEWL && m_reg < LCNT_W'(MAX_LENGTHS))
        begin
            mram_we = 1'b1;
            mram_wd = '{cnt: m_reg + 1'b1,
                        ord: ins_lord(lord_reg, j_reg, m_reg[LS_W-1:0])};
            lram_we = 1'b1;
            lram_wa = {li_reg, slot_reg, m_reg[LS_W-1:0]};
        end
        else if (state_reg == S_LCHK && kind_reg == KIND_INSERT && lram_q.len == l_reg)
        begin
            lram_we = 1'b1;
        end
    end

    trint_ram #(.WIDTH(32), .DEPTH(2**WADDR_W)) u_wram (
        .clk(clk), .we(wram_we), .waddr({li_reg, n_cur[WS_W-1:0]}), .wdata(w_reg),
        .raddr({li_reg, wslot_k}), .rdata(wram_q)
    );

    trint_ram #(.WIDTH($bits(meta_t)), .DEPTH(2**WADDR_W)) u_mram (
        .clk(clk), .we(mram_we), .waddr(mram_wa), .wdata(mram_wd),
        .raddr({li_reg, slot_reg}), .rdata(mram_q)
    );

    trint_ram #(.WIDTH($bits(lpt_t)), .DEPTH(2**LADDR_W)) u_lram (
        .clk(clk), .we(lram_we), .waddr(lram_wa), .wdata(lram_wd),
        .raddr(lram_ra), .rdata(lram_q)
    );

    logic [31:0] lerp_res;
    assign lerp_res = neg_reg ? (ybase_reg - dq_reg[31:0]) : (ybase_reg + dq_reg[31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_RSQ;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                wcnt_reg[i] <= '0;
                word_reg[i] <= '0;
            end
            kind_reg <= 1'b0;   ctx_reg <= '0;   typ_reg <= '0;   qi_reg <= '0;
            w_reg <= '0;   l_reg <= '0;   res_reg <= '0;   li_reg <= '0;
            k_reg <= '0;   j_reg <= '0;   m_reg <= '0;   lord_reg <= '0;
            slot_reg <= '0;   slotb_reg <= '0;   prevslot_reg <= '0;
            prevw_reg <= '0;   x1w_reg <= '0;   x2w_reg <= '0;
            prevl_reg <= '0;   prevv_reg <= '0;
            y_reg <= '0;   ya_reg <= '0;   p_reg <= '0;   rsq_reg <= '0;
            ybase_reg <= '0;   neg_reg <= 1'b0;   phase_reg <= 1'b0;   two_reg <= 1'b0;
            mul_a_reg <= '0;   mul_b_reg <= '0;   div_d_reg <= '0;
            dq_reg <= '0;   rem_reg <= '0;   cnt_reg <= '0;
            status_reg <= ST_OK;
            for (int i = 0; i < 3; i++)
                r_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind;
                        ctx_reg  <= context_req;
                        typ_reg  <= device_type;
                        w_reg    <= width;
                        l_reg    <= length;
                        res_reg  <= resist;
                        qi_reg   <= '0;
                        status_reg <= ST_OK;
                        for (int i = 0; i < 3; i++)
                            r_reg[i] <= '0;
                        state_reg <= (kind == KIND_INSERT) ? S_ISTART : S_QSTART;
                    end
                end
                S_ISTART:
                begin
                    li_reg <= li_i;
                    if (w_reg == '0 || l_reg == '0 || res_reg == '0 || itype_bad)
                    begin
                        status_reg <= ST_BAD;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        mul_a_reg <= res_reg;
                        mul_b_reg <= w_reg;
                        div_d_reg <= l_reg;
                        op_reg    <= OP_RSQ;
                        state_reg <= S_MUL;
                    end
                end
                S_QSTART:
                begin
                    li_reg    <= li_q;
                    phase_reg <= 1'b0;
                    k_reg     <= '0;
                    if (qtype_bad || wcnt_reg[li_q] == '0)
                    begin
                        p_reg     <= EMPTY_RES;
                        state_reg <= S_SCALE;
                    end
                    else
                        state_reg <= S_WRD;
                end
                S_MUL:
                begin
                    dq_reg    <= mul_a_reg * mul_b_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= qbit ? 32'(trial - {1'b0, div_d_reg}) : trial[31:0];
                    dq_reg  <= {dq_reg[62:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    unique case (op_reg)
                        OP_RSQ:
                        begin
                            rsq_reg <= (|dq_reg[63:32]) ? '1 : dq_reg[31:0];
                            k_reg   <= '0;
                            state_reg <= (n_cur == '0) ? S_NEWW : S_WRD;
                        end
                        OP_LERP:
                        begin
                            // length lerp feeds the width stage, width lerp the scale
                            y_reg     <= lerp_res;
                            state_reg <= S_LLDONE;
                        end
                        default:
                        begin
                            r_reg[qi_reg] <= (|dq_reg[63:40]) ? RES_MAX : dq_reg[39:0];
                            qi_reg <= qi_reg + 1'b1;
                            state_reg <= (qi_reg == 2'd2) ? S_OUT : S_QSTART;
                        end
                    endcase
                end
                S_WRD:
                begin
                    slot_reg  <= wslot_k;
                    state_reg <= S_WCHK;
                end
                S_WCHK:
                begin
                    prevw_reg    <= wram_q;
                    prevslot_reg <= slot_reg;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (wram_q == w_reg)
                            state_reg <= S_MRD;
                        else if (wram_q > w_reg)
                            state_reg <= S_NEWW;
                        else if (k_reg + 1'b1 == n_cur)
                        begin
                            k_reg     <= n_cur;
                            state_reg <= S_NEWW;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_WRD;
                        end
                    end
                    else
                    begin
                        if (wram_q >= w_reg)
                        begin
                            if (wram_q == w_reg || k_reg == '0)
                                two_reg <= 1'b0;
                            else
                            begin
                                two_reg   <= 1'b1;
                                slot_reg  <= prevslot_reg;
                                slotb_reg <= slot_reg;
                                x1w_reg   <= prevw_reg;
                                x2w_reg   <= wram_q;
                            end
                            state_reg <= S_MRD;
                        end
                        else if (k_reg + 1'b1 == n_cur)
                        begin
                            two_reg   <= 1'b0;
                            state_reg <= S_MRD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_WRD;
                        end
                    end
                end
                S_NEWW:
                begin
                    if (n_cur >= WCNT_W'(MAX_WIDTHS))
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        word_reg[li_reg] <= ins_word(word_cur, k_reg, n_cur[WS_W-1:0]);
                        wcnt_reg[li_reg] <= n_cur + 1'b1;
                        slot_reg  <= n_cur[WS_W-1:0];
                        m_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_NEWL;
                    end
                end
                S_MRD:
                    state_reg <= S_MCHK;
                S_MCHK:
                begin
                    m_reg    <= mram_q.cnt;
                    lord_reg <= mram_q.ord;
                    j_reg    <= '0;
                    if (mram_q.cnt == '0)
                    begin
                        y_reg     <= EMPTY_RES;
                        state_reg <= (kind_reg == KIND_INSERT) ? S_NEWL : S_LLDONE;
                    end
                    else
                        state_reg <= S_LRD;
                end
                S_LRD:
                    state_reg <= S_LCHK;
                S_LCHK:
                begin
                    prevl_reg <= lram_q.len;
                    prevv_reg <= lram_q.val;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (lram_q.len == l_reg)
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_OUT;
                        end
                        else if (lram_q.len > l_reg)
                            state_reg <= S_NEWL;
                        else if (j_reg + 1'b1 == m_reg)
                        begin
                            j_reg     <= m_reg;
                            state_reg <= S_NEWL;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_LRD;
                        end
                    end
                    else
                    begin
                        if (lram_q.len >= l_reg)
                        begin
                            if (lram_q.len == l_reg || j_reg == '0)
                            begin
                                y_reg     <= lram_q.val;
                                state_reg <= S_LLDONE;
                            end
                            else
                            begin
                                neg_reg   <= (lram_q.val < prevv_reg);
                                mul_a_reg <= (lram_q.val >= prevv_reg) ?
                                             lram_q.val - prevv_reg : prevv_reg - lram_q.val;
                                mul_b_reg <= l_reg - prevl_reg;
                                div_d_reg <= lram_q.len - prevl_reg;
                                ybase_reg <= prevv_reg;
                                op_reg    <= OP_LERP;
                                state_reg <= S_MUL;
                            end
                        end
                        else if (j_reg + 1'b1 == m_reg)
                        begin
                            y_reg     <= lram_q.val;
                            state_reg <= S_LLDONE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_LRD;
                        end
                    end
                end
                S_NEWL:
                begin
                    status_reg <= (m_reg >= LCNT_W'(MAX_LENGTHS)) ? ST_FULL : ST_OK;
                    state_reg  <= S_OUT;
                end
                S_LLDONE:
                begin
                    // between two widths: two length lookups, then one lerp across widths; else one lookup
                    if (!phase_reg && two_reg)
                    begin
                        ya_reg    <= y_reg;
                        phase_reg <= 1'b1;
                        slot_reg  <= slotb_reg;
                        state_reg <= S_MRD;
                    end
                    else if (!two_reg)
                    begin
                        p_reg     <= y_reg;
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        neg_reg   <= (y_reg < ya_reg);
                        mul_a_reg <= (y_reg >= ya_reg) ? y_reg - ya_reg : ya_reg - y_reg;
                        mul_b_reg <= w_reg - x1w_reg;
                        div_d_reg <= x2w_reg - x1w_reg;
                        ybase_reg <= ya_reg;
                        two_reg   <= 1'b0;
                        op_reg    <= OP_LERP;
                        state_reg <= S_MUL;
                    end
                end
                S_SCALE:
                begin
                    if (w_reg == '0)
                    begin
                        r_reg[qi_reg] <= RES_MAX;
                        qi_reg    <= qi_reg + 1'b1;
                        state_reg <= (qi_reg == 2'd2) ? S_OUT : S_QSTART;
                    end
                    else
                    begin
                        mul_a_reg <= p_reg;
                        mul_b_reg <= l_reg;
                        div_d_reg <= w_reg;
                        op_reg    <= OP_SCALE;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_OUT);
    assign status    = status_reg;
    assign r_static  = r_reg[0];
    assign r_dynlow  = r_reg[1];
    assign r_dynhigh = r_reg[2];

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_insert_no_values: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind_reg == KIND_INSERT) |-> (r_static == '0 && r_dynhigh == '0))
        else $error("insert result carries resistance values");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (n_cur <= WCNT_W'(MAX_WIDTHS)))
        else $error("width count beyond table size");

endmodule

// File: src/trint_ram.sv
module trint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// File: dv/transistor_resistance_interpolator_tb.sv
module transistor_resistance_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trint_pkg::*;

    typedef struct {
        logic        kind;
        logic [1:0]  ctx;
        logic [1:0]  dtype;
        logic [31:0] w;
        logic [31:0] l;
        logic [31:0] res;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [39:0] rs;
        logic [39:0] rdl;
        logic [39:0] rdh;
    } answer_t;

    localparam logic KIND_QUERY = 1'b1;
    localparam logic [1:0] CTX_STATIC  = 2'd0;
    localparam logic [1:0] CTX_DYNHIGH = 2'd1;
    localparam logic [1:0] CTX_DYNLOW  = 2'd2;
    localparam logic [1:0] CTX_POWER   = 2'd3;
    localparam int NUM_ITEMS = 1150;
    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        kind;
    logic [1:0]  context_req;
    logic [1:0]  device_type;
    logic [31:0] width;
    logic [31:0] length;
    logic [31:0] resist;
    logic [1:0]  status;
    logic [39:0] r_static;
    logic [39:0] r_dynlow;
    logic [39:0] r_dynhigh;

    transistor_resistance_interpolator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .kind(kind), .context_req(context_req), .device_type(device_type),
        .width(width), .length(length), .resist(resist), .status(status),
        .r_static(r_static), .r_dynlow(r_dynlow), .r_dynhigh(r_dynhigh)
    );

    // predictor copy of the table
    int unsigned wcnt [NUM_LISTS];
    logic [31:0] wpts [NUM_LISTS][MAX_WIDTHS];
    int unsigned lcnt [NUM_LISTS][MAX_WIDTHS];
    logic [31:0] lkey [NUM_LISTS][MAX_WIDTHS][MAX_LENGTHS];
    logic [31:0] lval [NUM_LISTS][MAX_WIDTHS][MAX_LENGTHS];

    request_t pending_q[$];
    answer_t  expected_q[$];
    int       errors;
    int       n_inserts, n_queries, n_full, n_bad;
    longint   cycles;
    int       gap;

    function automatic logic [31:0] lerp32(logic [31:0] x, logic [31:0] x1,
                                           logic [31:0] y1, logic [31:0] x2,
                                           logic [31:0] y2);
        logic [63:0] dx;
        logic [63:0] span;
        if (x2 <= x1 || x <= x1)
            return y1;
        dx = 64'(x - x1);
        span = 64'(x2 - x1);
        if (y2 >= y1)
            return y1 + 32'((64'(y2 - y1) * dx) / span);
        return y1 - 32'((64'(y1 - y2) * dx) / span);
    endfunction

    function automatic logic [31:0] length_value(int li, int ws, logic [31:0] l);
        int n;
        n = lcnt[li][ws];
        if (n == 0)
            return EMPTY_RES;
        for (int k = 0; k < n; k++) begin
            if (lkey[li][ws][k] == l || (lkey[li][ws][k] > l && k == 0))
                return lval[li][ws][k];
            if (lkey[li][ws][k] > l)
                return lerp32(l, lkey[li][ws][k-1], lval[li][ws][k-1],
                              lkey[li][ws][k], lval[li][ws][k]);
        end
        return lval[li][ws][n-1];
    endfunction

    function automatic logic [31:0] sheet_value(logic [1:0] ctx, logic [1:0] t,
                                                logic [31:0] w, logic [31:0] l);
        int li;
        int n;
        if (int'(t) >= NUM_TYPES)
            return EMPTY_RES;
        li = int'(ctx) * NUM_TYPES + int'(t);
        n = wcnt[li];
        if (n == 0)
            return EMPTY_RES;
        for (int k = 0; k < n; k++) begin
            if (wpts[li][k] == w || (wpts[li][k] > w && k == 0))
                return length_value(li, k, l);
            if (wpts[li][k] > w)
                return lerp32(w, wpts[li][k-1], length_value(li, k-1, l),
                              wpts[li][k], length_value(li, k, l));
        end
        return length_value(li, n-1, l);
    endfunction

    function automatic logic [39:0] channel_res(logic [31:0] p, logic [31:0] w,
                                                logic [31:0] l);
        logic [63:0] r;
        if (w == 0)
            return RES_MAX;
        r = (64'(p) * 64'(l)) / 64'(w);
        return (r > 64'(RES_MAX)) ? RES_MAX : r[39:0];
    endfunction

    function automatic logic [1:0] store_point(request_t rq);
        int li, n, k, m;
        logic [63:0] rsq;
        if (rq.w == 0 || rq.l == 0 || rq.res == 0 || int'(rq.dtype) >= NUM_TYPES)
            return ST_BAD;
        rsq = (64'(rq.res) * 64'(rq.w)) / 64'(rq.l);
        if (rsq > 64'hFFFF_FFFF)
            rsq = 64'hFFFF_FFFF;
        li = int'(rq.ctx) * NUM_TYPES + int'(rq.dtype);
        n = wcnt[li];
        k = 0;
        while (k < n && wpts[li][k] < rq.w)
            k++;
        if (k == n || wpts[li][k] != rq.w) begin
            if (n >= MAX_WIDTHS)
                return ST_FULL;
            for (int j = n; j > k; j--) begin
                wpts[li][j] = wpts[li][j-1];
                lcnt[li][j] = lcnt[li][j-1];
                lkey[li][j] = lkey[li][j-1];
                lval[li][j] = lval[li][j-1];
            end
            wpts[li][k] = rq.w;
            lcnt[li][k] = 0;
            wcnt[li] = n + 1;
        end
        m = lcnt[li][k];
        for (int j = 0; j <= m; j++) begin
            if (j < m && lkey[li][k][j] < rq.l)
                continue;
            if (j < m && lkey[li][k][j] == rq.l) begin
                lval[li][k][j] = rsq[31:0];
                return ST_OK;
            end
            if (m >= MAX_LENGTHS)
                return ST_FULL;
            for (int i = m; i > j; i--) begin
                lkey[li][k][i] = lkey[li][k][i-1];
                lval[li][k][i] = lval[li][k][i-1];
            end
            lkey[li][k][j] = rq.l;
            lval[li][k][j] = rsq[31:0];
            lcnt[li][k] = m + 1;
            return ST_OK;
        end
        return ST_OK;
    endfunction

    function automatic answer_t predict_answer(request_t rq);
        answer_t a;
        a = '{status: ST_OK, rs: '0, rdl: '0, rdh: '0};
        if (rq.kind == KIND_INSERT) begin
            a.status = store_point(rq);
        end else begin
            a.rs  = channel_res(sheet_value(CTX_STATIC, rq.dtype, rq.w, rq.l), rq.w, rq.l);
            a.rdl = channel_res(sheet_value(CTX_DYNLOW, rq.dtype, rq.w, rq.l), rq.w, rq.l);
            a.rdh = channel_res(sheet_value(CTX_DYNHIGH, rq.dtype, rq.w, rq.l), rq.w, rq.l);
        end
        return a;
    endfunction

    function automatic request_t mk(logic k, logic [1:0] c, logic [1:0] t,
                                    logic [31:0] w, logic [31:0] l, logic [31:0] r);
        request_t rq;
        rq.kind = k;
        rq.ctx = c;
        rq.dtype = t;
        rq.w = w;
        rq.l = l;
        rq.res = r;
        return rq;
    endfunction

    // mostly small grid values so points collide and interpolation is exercised
    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'($urandom_range(0, 3));
            2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(1, 12)) << $urandom_range(12, 17);
        endcase
    endfunction

    function automatic logic [31:0] rand_res();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 2));
            default: return 32'($urandom_range(1, 5000)) << 8;
        endcase
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        request_t rq;
        for (int i = 0; i < NUM_LISTS; i++) begin
            wcnt[i] = 0;
            for (int j = 0; j < MAX_WIDTHS; j++)
                lcnt[i][j] = 0;
        end
        errors = 0;
        n_inserts = 0;
        n_queries = 0;
        n_full = 0;
        n_bad = 0;

        // empty table, zero query width, rejected inserts, extremes
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd0, 32'h0001_0000, 32'h0001_0000, '0));
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd3, '0, 32'hFFFF_FFFF, '0));
        pending_q.push_back(mk(KIND_QUERY, CTX_POWER, 2'd1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd0, '0, 32'h1_0000, 32'h100));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd0, 32'h1_0000, '0, 32'h100));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd0, 32'h1_0000, 32'h1_0000, '0));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd1, 32'h2_0000, 32'h1_0000, 32'h1000));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd1, 32'h1_0000, 32'h1_0000, 32'h3000));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd1, 32'h1_0000, 32'h4_0000, 32'h800));
        pending_q.push_back(mk(KIND_INSERT, CTX_STATIC, 2'd1, 32'h1_0000, 32'h1_0000, 32'h2000));
        pending_q.push_back(mk(KIND_INSERT, CTX_DYNLOW, 2'd1, 32'hFFFF_FFFF, 32'h1,
                               32'hFFFF_FFFF));
        pending_q.push_back(mk(KIND_INSERT, CTX_DYNHIGH, 2'd1, 32'h1, 32'hFFFF_FFFF, 32'h1));
        pending_q.push_back(mk(KIND_INSERT, CTX_POWER, 2'd2, 32'h3_0000, 32'h1_0000, 32'h500));
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd1, 32'h1_8000, 32'h2_0000, '0));
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd1, 32'h8000, 32'h8000, '0));
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd1, 32'h5_0000, 32'h9_0000, '0));
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
        pending_q.push_back(mk(KIND_QUERY, CTX_STATIC, 2'd1, '0, 32'h1_0000, '0));
        // fill one list's widths past capacity
        for (int i = 0; i <= MAX_WIDTHS; i++)
            pending_q.push_back(mk(KIND_INSERT, CTX_DYNHIGH, 2'd3, 32'(i + 1) << 16,
                                   32'h1_0000, 32'h100 * (i + 1)));

        for (int i = 0; i < NUM_ITEMS; i++) begin
            rq.kind = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_QUERY;
            rq.ctx = 2'($urandom);
            rq.dtype = 2'($urandom);
            rq.w = rand_dim();
            rq.l = rand_dim();
            rq.res = rand_res();
            pending_q.push_back(rq);
        end
        // length overflow on one width
        for (int i = 0; i <= MAX_LENGTHS; i++)
            pending_q.push_back(mk(KIND_INSERT, CTX_DYNLOW, 2'd0, 32'h7_0000,
                                   32'(i + 1) << 20, 32'h1234));
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            kind <= KIND_INSERT;
            context_req <= '0;
            device_type <= '0;
            width <= '0;
            length <= '0;
            resist <= '0;
            gap <= 0;
        end else if (start && !busy) begin
            start <= 1'b0;
            gap <= $urandom_range(0, 5);
        end else if (!start) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (pending_q.size() > 0 && !busy) begin
                request_t rq;
                rq = pending_q.pop_front();
                expected_q.push_back(predict_answer(rq));
                if (rq.kind == KIND_INSERT)
                    n_inserts++;
                else
                    n_queries++;
                kind <= rq.kind;
                context_req <= rq.ctx;
                device_type <= rq.dtype;
                width <= rq.w;
                length <= rq.l;
                resist <= rq.res;
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                answer_t e;
                e = expected_q.pop_front();
                if (e.status == ST_FULL)
                    n_full++;
                if (e.status == ST_BAD)
                    n_bad++;
                if (status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    errors++;
                end
                if (r_static !== e.rs) begin
                    $error("r_static: expected %0h, got %0h", e.rs, r_static);
                    errors++;
                end
                if (r_dynlow !== e.rdl) begin
                    $error("r_dynlow: expected %0h, got %0h", e.rdl, r_dynlow);
                    errors++;
                end
                if (r_dynhigh !== e.rdh) begin
                    $error("r_dynhigh: expected %0h, got %0h", e.rdh, r_dynhigh);
                    errors++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while ((pending_q.size() > 0 || expected_q.size() > 0 || start || busy)
               && cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
        end else begin
            repeat (20) @(posedge clk);
            $display("covered %0d inserts and %0d queries; %0d rejected, %0d hit a full table",
                     n_inserts, n_queries, n_bad, n_full);
            if (errors == 0 && expected_q.size() == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
